// ===== design/multi_slot_periodic_tick_timer_unit_defines.svh =====
// Assertion macros used by the timer output buffer
`ifndef MULTI_SLOT_PERIODIC_TICK_TIMER_UNIT_DEFINES_SVH
`define MULTI_SLOT_PERIODIC_TICK_TIMER_UNIT_DEFINES_SVH

// same-cycle implication
`define MSPTT_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("timer assertion failed");

// next-cycle implication
`define MSPTT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("timer assertion failed");

`endif

// ===== design/msptt_pkg.sv =====
// Package: sizes and shared types of the multi-slot tick timer
`timescale 1ns / 1ps
`default_nettype none
package msptt_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int CNT_W       = 32;
    localparam int MASK_W      = 4;
    localparam int CFG_ADDR_W  = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((MASK_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MASK_W - CNT_W;

    typedef struct packed {
        logic             fire;
        logic [CNT_W-1:0] last_fire;
    } slot_result_t;

endpackage
`default_nettype wire

// ===== design/msptt_slot.sv =====
// One timer slot: due check and last-fire update for one tick
`timescale 1ns / 1ps
`default_nettype none
module msptt_slot (
    input  wire logic                        tick,
    input  wire logic [msptt_pkg::CNT_W-1:0] interval,
    input  wire logic [msptt_pkg::CNT_W-1:0] last_fire,
    input  wire logic [msptt_pkg::CNT_W-1:0] count_new,
    output msptt_pkg::slot_result_t          result
);

    logic                        active;
    logic [msptt_pkg::CNT_W-1:0] due;
    logic                        hit;
    logic [msptt_pkg::CNT_W-1:0] last_upd;

    always_comb
    begin
        active   = tick && (interval != '0);
        due      = last_fire + interval;
        hit      = active && (due <= count_new);
        last_upd = hit ? count_new : last_fire;
        result.fire = hit;
        if (active && (last_upd > count_new))
        begin
            result.last_fire = '0;
        end
        else
        begin
            result.last_fire = last_upd;
        end
    end

endmodule
`default_nettype wire

// ===== design/msptt_out_buf.sv =====
// Output stage: result register with one skid entry
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_periodic_tick_timer_unit_defines.svh"
module msptt_out_buf (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [msptt_pkg::OUT_TDATA_W-1:0] in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [msptt_pkg::OUT_TDATA_W-1:0]      out_data
);

    logic                                 main_valid_reg;
    logic                                 skid_valid_reg;
    logic [msptt_pkg::OUT_TDATA_W-1:0]    main_data_reg;
    logic [msptt_pkg::OUT_TDATA_W-1:0]    skid_data_reg;
    logic                                 in_take;

    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (main_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (in_take)
        begin
            if (main_valid_reg && !out_ready)
            begin
                skid_data_reg <= in_data;
            end
            else
            begin
                main_data_reg <= in_data;
            end
        end
    end

    `MSPTT_ASSERT_SAME(a_skid_needs_main, clk, rst_n, skid_valid_reg, main_valid_reg)
    `MSPTT_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, in_take && main_valid_reg && !out_ready, skid_valid_reg)
    `MSPTT_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && out_ready, main_valid_reg && !skid_valid_reg)

endmodule
`default_nettype wire

// ===== design/multi_slot_periodic_tick_timer_unit.sv =====
// Top level: multi-slot periodic tick timer
`timescale 1ns / 1ps
`default_nettype none
// A result word is registered in the output buffer when its input word is accepted.
// Throughput: one word per cycle if the skid is empty; all slots are checked in parallel in one pass.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (rst_n low, asynchronous) clears the tick count, the intervals,
// the last-fire times and the output buffer. Configuration is always ready.
module multi_slot_periodic_tick_timer_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [msptt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // tick, zero pad
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [msptt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // fire_mask, now_ticks, zero pad
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [msptt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [msptt_pkg::CNT_W-1:0]          cfg_data
);

    logic [msptt_pkg::CNT_W-1:0]        count_reg;
    logic [msptt_pkg::CNT_W-1:0]        count_next;
    logic [msptt_pkg::CNT_W-1:0]        interval_reg [msptt_pkg::NUM_SLOTS];
    logic [msptt_pkg::CNT_W-1:0]        last_reg     [msptt_pkg::NUM_SLOTS];
    msptt_pkg::slot_result_t            slot_res     [msptt_pkg::NUM_SLOTS];
    logic [msptt_pkg::MASK_W-1:0]       fire_mask;
    logic                               tick;
    logic                               in_accept;
    logic                               buf_ready;
    logic [msptt_pkg::OUT_TDATA_W-1:0]  result_word;

    assign tick          = s_axis_tdata[0];
    assign s_axis_tready = buf_ready;
    assign in_accept     = s_axis_tvalid && buf_ready;
    assign cfg_ready     = 1'b1;
    assign count_next    = tick ? (count_reg + msptt_pkg::CNT_W'(1)) : count_reg;

    for (genvar i = 0; i < msptt_pkg::NUM_SLOTS; i++)
    begin : g_slot
        msptt_slot u_slot (
            .tick      (tick),
            .interval  (interval_reg[i]),
            .last_fire (last_reg[i]),
            .count_new (count_next),
            .result    (slot_res[i])
        );
    end

    for (genvar i = 0; i < msptt_pkg::MASK_W; i++)
    begin : g_mask
        if (i < msptt_pkg::NUM_SLOTS)
        begin : g_used
            assign fire_mask[i] = slot_res[i].fire;
        end
        else
        begin : g_unused
            assign fire_mask[i] = 1'b0;
        end
    end

    assign result_word = {{msptt_pkg::OUT_PAD_W{1'b0}}, count_next, fire_mask};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msptt_pkg::NUM_SLOTS; i++)
            begin
                interval_reg[i] <= '0;
                last_reg[i]     <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < msptt_pkg::NUM_SLOTS; i++)
            begin
                if (cfg_valid && (cfg_addr == msptt_pkg::CFG_ADDR_W'(i)))
                begin
                    interval_reg[i] <= cfg_data;
                    last_reg[i]     <= '0;
                end
                else if (in_accept)
                begin
                    last_reg[i] <= slot_res[i].last_fire;
                end
            end
        end
    end

    msptt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (buf_ready),
        .in_data   (result_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/multi_slot_periodic_tick_timer_unit_tb.sv =====
// Self-checking testbench of the multi-slot tick timer: directed table, then random phases
`timescale 1ns / 1ps
module multi_slot_periodic_tick_timer_unit_tb;

    localparam int CLK_HALF    = 10;
    localparam int LIMIT       = 500000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 100;
    localparam int PLAN_ROWS   = 24;

    localparam logic [msptt_pkg::CFG_ADDR_W-1:0] IDX_SLOT0  = 8'd0;
    localparam logic [msptt_pkg::CFG_ADDR_W-1:0] IDX_SLOT1  = 8'd1;
    localparam logic [msptt_pkg::CFG_ADDR_W-1:0] IDX_SLOT2  = 8'd2;
    localparam logic [msptt_pkg::CFG_ADDR_W-1:0] IDX_SLOT3  = 8'd3;
    localparam logic [msptt_pkg::CFG_ADDR_W-1:0] IDX_UNUSED =
        msptt_pkg::CFG_ADDR_W'(msptt_pkg::NUM_SLOTS);
    localparam logic [msptt_pkg::CFG_ADDR_W-1:0] IDX_TOP    = 8'hFF;

    typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [msptt_pkg::CFG_ADDR_W-1:0]   addr;
        logic [msptt_pkg::CNT_W-1:0]        value;
        bit                                 typed;
        logic [msptt_pkg::MASK_W-1:0]       mask;
        logic [msptt_pkg::CNT_W-1:0]        now;
    } plan_row_t;

    typedef struct packed {
        logic [msptt_pkg::MASK_W-1:0] mask;
        logic [msptt_pkg::CNT_W-1:0]  now;
    } fire_report_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [msptt_pkg::IN_TDATA_W-1:0]       s_axis_tdata = '0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [msptt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [msptt_pkg::CFG_ADDR_W-1:0]       cfg_addr = '0;
    logic [msptt_pkg::CNT_W-1:0]            cfg_data = '0;

    logic [msptt_pkg::CNT_W-1:0]  timer_count;
    logic [msptt_pkg::CNT_W-1:0]  timer_last [msptt_pkg::NUM_SLOTS];
    logic [msptt_pkg::CNT_W-1:0]  timer_interval [msptt_pkg::NUM_SLOTS];

    fire_report_t      awaited_reports [$];
    fire_report_t      head_report;
    plan_row_t         plan [PLAN_ROWS];

    bit  calm = 1'b0;
    int  rx_stall = 0;
    int  cycle_count = 0;
    int  errors = 0;
    int  items_sent = 0;
    int  reports_checked = 0;
    int  cfg_writes = 0;
    int  fires_seen = 0;

    multi_slot_periodic_tick_timer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // tick, zero pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // fire_mask, now_ticks, zero pad
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [msptt_pkg::CNT_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 75)
            return $urandom_range(1, 40);
        if (r < 85)
            return $urandom_range(41, 400);
        if (r < 93)
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic void reset_timer_mirror();
        int i;
        timer_count = '0;
        for (i = 0; i < msptt_pkg::NUM_SLOTS; i++)
        begin
            timer_last[i]     = '0;
            timer_interval[i] = '0;
        end
    endfunction

    function automatic fire_report_t advance_timer(input bit t);
        fire_report_t                 rep;
        logic [msptt_pkg::CNT_W-1:0]  due;
        int                           i;
        rep.mask = '0;
        if (t)
        begin
            timer_count = timer_count + 1'b1;
            for (i = 0; i < msptt_pkg::NUM_SLOTS; i++)
            begin
                if (timer_interval[i] != '0)
                begin
                    due = timer_last[i] + timer_interval[i];
                    if (due <= timer_count)
                    begin
                        timer_last[i] = timer_count;
                        if (i < msptt_pkg::MASK_W)
                            rep.mask[i] = 1'b1;
                    end
                    if (timer_last[i] > timer_count)
                        timer_last[i] = '0;
                end
            end
        end
        rep.now = timer_count;
        return rep;
    endfunction

    task automatic write_interval_reg(input logic [msptt_pkg::CFG_ADDR_W-1:0] idx,
                                      input logic [msptt_pkg::CNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < msptt_pkg::NUM_SLOTS)
        begin
            timer_interval[idx] = value;
            timer_last[idx]     = '0;
        end
        cfg_writes++;
    endtask

    task automatic send_tick(input bit t, input bit typed, input fire_report_t typed_rep);
        int           gap;
        fire_report_t rep;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(msptt_pkg::IN_TDATA_W-1){1'b0}}, t};
        do @(posedge clk); while (!s_axis_tready);
        rep = advance_timer(t);
        awaited_reports.push_back(typed ? typed_rep : rep);
        items_sent++;
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_reports.size());
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("unexpected result word: fire_mask %h now_ticks %h",
                       m_axis_tdata[msptt_pkg::MASK_W-1:0],
                       m_axis_tdata[msptt_pkg::MASK_W +: msptt_pkg::CNT_W]);
                errors++;
            end
            else
            begin
                head_report = awaited_reports.pop_front();
                if (m_axis_tdata[msptt_pkg::MASK_W-1:0] !== head_report.mask)
                begin
                    $error("fire_mask: expected %h, got %h",
                           head_report.mask, m_axis_tdata[msptt_pkg::MASK_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[msptt_pkg::MASK_W +: msptt_pkg::CNT_W] !== head_report.now)
                begin
                    $error("now_ticks: expected %h, got %h",
                           head_report.now,
                           m_axis_tdata[msptt_pkg::MASK_W +: msptt_pkg::CNT_W]);
                    errors++;
                end
                if (m_axis_tdata[msptt_pkg::OUT_TDATA_W-1 -: msptt_pkg::OUT_PAD_W] !== '0)
                begin
                    $error("pad: expected %h, got %h", {msptt_pkg::OUT_PAD_W{1'b0}},
                           m_axis_tdata[msptt_pkg::OUT_TDATA_W-1 -: msptt_pkg::OUT_PAD_W]);
                    errors++;
                end
                reports_checked++;
                fires_seen += $countones(head_report.mask);
            end
        end
        if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                rx_stall = pick_gap(1'b0);
        end
    end

    initial
    begin
        int           r;
        int           p;
        int           n;
        int           s;
        fire_report_t typed_rep;

        reset_timer_mirror();

        plan[0]  = '{ROW_TICK, '0,         32'd0,         1'b1, 4'h0, 32'd0};
        plan[1]  = '{ROW_TICK, '0,         32'd1,         1'b1, 4'h0, 32'd1};
        plan[2]  = '{ROW_CFG,  IDX_SLOT0,  32'd1,         1'b0, 4'h0, 32'd0};
        plan[3]  = '{ROW_CFG,  IDX_SLOT1,  32'd3,         1'b0, 4'h0, 32'd0};
        plan[4]  = '{ROW_CFG,  IDX_SLOT2,  32'hFFFF_FFFF, 1'b0, 4'h0, 32'd0};
        plan[5]  = '{ROW_CFG,  IDX_SLOT3,  32'h8000_0000, 1'b0, 4'h0, 32'd0};
        plan[6]  = '{ROW_CFG,  IDX_UNUSED, 32'd7,         1'b0, 4'h0, 32'd0};
        plan[7]  = '{ROW_CFG,  IDX_TOP,    32'hFFFF_FFFF, 1'b0, 4'h0, 32'd0};
        plan[8]  = '{ROW_TICK, '0,         32'd1,         1'b1, 4'h1, 32'd2};
        plan[9]  = '{ROW_TICK, '0,         32'd0,         1'b1, 4'h0, 32'd2};
        plan[10] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[11] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[12] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[13] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[14] = '{ROW_CFG,  IDX_SLOT1,  32'd2,         1'b0, 4'h0, 32'd0};
        plan[15] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[16] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[17] = '{ROW_CFG,  IDX_SLOT0,  32'd0,         1'b0, 4'h0, 32'd0};
        plan[18] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[19] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[20] = '{ROW_CFG,  IDX_SLOT2,  32'd0,         1'b0, 4'h0, 32'd0};
        plan[21] = '{ROW_CFG,  IDX_SLOT3,  32'd0,         1'b0, 4'h0, 32'd0};
        plan[22] = '{ROW_TICK, '0,         32'd1,         1'b0, 4'h0, 32'd0};
        plan[23] = '{ROW_TICK, '0,         32'd0,         1'b0, 4'h0, 32'd0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
                write_interval_reg(plan[r].addr, plan[r].value);
            else
            begin
                typed_rep.mask = plan[r].mask;
                typed_rep.now  = plan[r].now;
                send_tick(plan[r].value[0], plan[r].typed, typed_rep);
            end
        end

        typed_rep = '0;
        for (p = 0; p < PHASES; p++)
        begin
            calm = (p != 0) && ($urandom_range(0, 3) == 0);
            for (s = 0; s < msptt_pkg::NUM_SLOTS; s++)
            begin
                if (p == 0)
                    write_interval_reg(msptt_pkg::CFG_ADDR_W'(s), 32'd1);
                else if (p == PHASES - 1)
                    write_interval_reg(msptt_pkg::CFG_ADDR_W'(s), 32'hFFFF_FFFF);
                else if ($urandom_range(0, 3) != 0)
                    write_interval_reg(msptt_pkg::CFG_ADDR_W'(s), pick_interval());
            end
            if ($urandom_range(0, 2) == 0)
                write_interval_reg(
                    msptt_pkg::CFG_ADDR_W'($urandom_range(msptt_pkg::NUM_SLOTS, 255)),
                    $urandom);
            n = $urandom_range(PHASE_ITEMS - 20, PHASE_ITEMS + 20);
            for (r = 0; r < n; r++)
                send_tick($urandom_range(0, 99) < 85, 1'b0, typed_rep);
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d tick words over %0d interval settings, %0d register writes",
                 items_sent, PHASES + 1, cfg_writes);
        $display("checked %0d result words, %0d slot firings, final count %0d",
                 reports_checked, fires_seen, timer_count);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
